// ===== src/deq_pkg.sv =====
// ----------------------------------------------------------------------------
// deq_pkg: shared types and constants for the double-ended queue
// Action and status codes and the fixed field widths of both channels.
// ----------------------------------------------------------------------------
package deq_pkg;

  // Field widths of the command and response items
  localparam int ACT_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 7;

  // Compact drops every entry whose 1-based position is a multiple of this
  localparam int DROP_EVERY = 3;
  localparam logic [1:0] PHASE_LAST = 2'(DROP_EVERY - 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_CLEAR      = 3'd4,
    ACT_COMPACT    = 3'd5
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

// ===== src/deq_cmd_if.sv =====
// ----------------------------------------------------------------------------
// deq_cmd_if: command channel of the double-ended queue
// Valid/ready handshake carrying the action code and the word to push.
// ----------------------------------------------------------------------------
interface deq_cmd_if;
  import deq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic        [ACT_W-1:0]   action;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, action, value, input ready);
  modport sink   (input valid, action, value, output ready);
endinterface

// ===== src/deq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// deq_rsp_if: response channel of the double-ended queue
// Valid/ready handshake carrying the popped word, status and occupancy.
// ----------------------------------------------------------------------------
interface deq_rsp_if;
  import deq_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  popped_word;
  logic        [STATUS_W-1:0] status;
  logic        [OCC_W-1:0]    occupancy;
  logic                       is_empty;

  modport source (output valid, popped_word, status, occupancy, is_empty, input ready);
  modport sink   (input valid, popped_word, status, occupancy, is_empty, output ready);
endinterface

// ===== src/deq_ram.sv =====
// ----------------------------------------------------------------------------
// deq_ram: ring store of the double-ended queue
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  logic [WORD_BITS-1:0]         wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic [WORD_BITS-1:0]         rd_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue: bounded double-ended queue in a ring store
// Push and pop at both ends, clear, and compact (drops every third entry
// counted from the back end), one response item per command item.
// ----------------------------------------------------------------------------
//  channel  dir  handshake    payload
//  cmd      in   valid/ready  action, value
//  rsp      out  valid/ready  popped_word, status, occupancy, is_empty
//
//  Push, clear, no-op and refused items and compacts on under three entries
//  go straight to the result state; good pops first wait for the registered
//  store read; larger compacts move one entry per cycle via the store ports.
//  cmd.ready is high only while the sequencer is idle; a finished response
//  waits in the output register, so a stalled rsp holds up at most one item.
//  Synchronous reset empties the queue; the store contents are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input logic      clk,
  input logic      rst,
  deq_cmd_if.sink  cmd,
  deq_rsp_if.source rsp
);
  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] POS_LAST   = AW'(DEPTH - 1);
  localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);
  localparam logic [CW:0]   RING_SIZE  = (CW + 1)'(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_CMP  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    ring_inc = (p == POS_LAST) ? '0 : p + AW'(1);
  endfunction

  state_t               state, state_next;
  logic [AW-1:0]        back, back_next;
  logic [CW-1:0]        count, count_next;
  logic [AW-1:0]        src_pos, src_pos_next;
  logic [AW-1:0]        dst_pos, dst_pos_next;
  logic [CW-1:0]        k_cnt, k_cnt_next;
  logic [CW-1:0]        kept, kept_next;
  logic [1:0]           phase, phase_next;
  logic                 pend, pend_next;
  logic                 pend_keep, pend_keep_next;
  logic [WORD_BITS-1:0] res_word, res_word_next;
  status_t              res_status, res_status_next;
  logic                 out_valid;
  logic                 load;
  logic                 cmp_last;

  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [WORD_BITS-1:0] wr_data, rd_data;

  logic [WORD_BITS-1:0] word_in;
  logic [CW-1:0]        ring_off;
  logic [CW:0]          ring_sum;
  logic [AW-1:0]        ring_pos;
  logic [AW-1:0]        back_dec;
  logic                 is_full, is_none;

  deq_ram #(.DEPTH(DEPTH), .WORD_BITS(WORD_BITS)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared ring adder: back + offset modulo DEPTH
  assign ring_off = (cmd.action == ACT_POP_FRONT) ? count - CW'(1) : count;
  always_comb begin
    ring_sum = (CW + 1)'(back) + (CW + 1)'(ring_off);
    if (ring_sum >= RING_SIZE) begin
      ring_sum = ring_sum - RING_SIZE;
    end
    ring_pos = AW'(ring_sum);
  end

  assign back_dec = (back == '0) ? POS_LAST : back - AW'(1);
  assign word_in  = WORD_BITS'($unsigned(cmd.value));
  assign is_full  = (count >= COUNT_FULL);
  assign is_none  = (count == '0);
  assign cmp_last = (state == S_CMP) && (k_cnt == count);
  assign cmd.ready = (state == S_IDLE);

  // Sequencer
  always_comb begin
    state_next      = state;
    back_next       = back;
    count_next      = count;
    src_pos_next    = src_pos;
    dst_pos_next    = dst_pos;
    k_cnt_next      = k_cnt;
    kept_next       = kept;
    phase_next      = phase;
    pend_next       = pend;
    pend_keep_next  = pend_keep;
    res_word_next   = res_word;
    res_status_next = res_status;
    wr_en           = 1'b0;
    wr_addr         = dst_pos;
    wr_data         = rd_data;
    rd_en           = 1'b0;
    rd_addr         = src_pos;
    load            = 1'b0;
    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          res_word_next   = '0;
          res_status_next = ST_OK;
          state_next      = S_OUT;
          case (cmd.action)
            ACT_PUSH_BACK: begin
              if (is_full) begin
                res_status_next = ST_FULL;
              end else begin
                back_next  = back_dec;
                wr_en      = 1'b1;
                wr_addr    = back_dec;
                wr_data    = word_in;
                count_next = count + CW'(1);
              end
            end
            ACT_PUSH_FRONT: begin
              if (is_full) begin
                res_status_next = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = ring_pos;
                wr_data    = word_in;
                count_next = count + CW'(1);
              end
            end
            ACT_POP_BACK: begin
              if (is_none) begin
                res_status_next = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = back;
                back_next  = ring_inc(back);
                count_next = count - CW'(1);
                state_next = S_POP;
              end
            end
            ACT_POP_FRONT: begin
              if (is_none) begin
                res_status_next = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = ring_pos;
                count_next = count - CW'(1);
                state_next = S_POP;
              end
            end
            ACT_CLEAR: begin
              count_next = '0;
              back_next  = '0;
            end
            ACT_COMPACT: begin
              if (count >= CW'(DROP_EVERY)) begin
                src_pos_next = back;
                dst_pos_next = back;
                k_cnt_next   = '0;
                kept_next    = '0;
                phase_next   = '0;
                pend_next    = 1'b0;
                state_next   = S_CMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_POP: begin
        res_word_next = rd_data;
        state_next    = S_OUT;
      end
      S_CMP: begin
        // write back the entry read last cycle unless it is dropped
        if (pend && pend_keep) begin
          wr_en        = 1'b1;
          dst_pos_next = ring_inc(dst_pos);
          kept_next    = kept + CW'(1);
        end
        // read the next entry, or finish
        if (!cmp_last) begin
          rd_en          = 1'b1;
          src_pos_next   = ring_inc(src_pos);
          k_cnt_next     = k_cnt + CW'(1);
          pend_next      = 1'b1;
          pend_keep_next = (phase != PHASE_LAST);
          phase_next     = (phase == PHASE_LAST) ? '0 : phase + 2'd1;
        end else begin
          pend_next  = 1'b0;
          count_next = kept_next;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || rsp.ready) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      back      <= '0;
      count     <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      back  <= back_next;
      count <= count_next;
      pend  <= pend_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    src_pos    <= src_pos_next;
    dst_pos    <= dst_pos_next;
    k_cnt      <= k_cnt_next;
    kept       <= kept_next;
    phase      <= phase_next;
    pend_keep  <= pend_keep_next;
    res_word   <= res_word_next;
    res_status <= res_status_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      rsp.popped_word <= VALUE_W'(res_word);
      rsp.status      <= res_status;
      rsp.occupancy   <= OCC_W'(count);
      rsp.is_empty    <= is_none;
    end
  end

  assign rsp.valid = out_valid;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_FULL)
    else $error("entry count above store depth");

  a_pop_reads: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && !is_none &&
     (cmd.action == ACT_POP_BACK || cmd.action == ACT_POP_FRONT)) |=> state == S_POP)
    else $error("pop did not wait for store read");

  a_compact_shrinks: assert property (@(posedge clk) disable iff (rst)
    cmp_last |=> count <= $past(count))
    else $error("compact grew the queue");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("response item appeared outside result state");

  a_back_range: assert property (@(posedge clk) disable iff (rst)
    back <= POS_LAST)
    else $error("back position outside ring");

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the double-ended queue
// Drives command items from a backlog with random idle gaps and stalls the
// response side at random. A behavioural copy of the ring store predicts
// every response item, which is compared field by field on arrival.
// ----------------------------------------------------------------------------
module tb;
  import deq_pkg::*;

  localparam int DEPTH        = 64;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_ITEMS = 1350;
  localparam int PRINT_CAP    = 40;

  // Spare action codes: the block treats them as no-ops
  localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_ANY, MIX_SQUEEZE} mix_t;

  typedef struct {
    logic        [ACT_W-1:0]   action;
    logic signed [VALUE_W-1:0] value;
  } cmd_item_t;

  typedef struct {
    logic signed [VALUE_W-1:0] word;
    status_t                   status;
    logic        [OCC_W-1:0]   occ;
    logic                      empty;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  deq_cmd_if cmd_ch ();
  deq_rsp_if rsp_ch ();

  double_ended_queue #(.DEPTH(DEPTH), .WORD_BITS(VALUE_W)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the queue
  logic signed [VALUE_W-1:0] shadow_ring [DEPTH];
  int shadow_back = 0;
  int shadow_held = 0;

  cmd_item_t cmd_backlog [$];
  reply_t    reply_fifo  [$];

  int mismatches  = 0;
  int cycle_count = 0;
  int idle_left   = 0;
  int stall_left  = 0;
  int drv_quiet   = 0;
  int mon_quiet   = 0;

  always #4 clk = ~clk;

  // Apply one action to the shadow queue and return the response it yields
  function automatic reply_t apply_deque_action(logic [ACT_W-1:0] act,
                                                logic signed [VALUE_W-1:0] val);
    reply_t r;
    int     kept;
    int     k;
    r.word   = '0;
    r.status = ST_OK;
    case (act)
      ACT_PUSH_BACK: begin
        if (shadow_held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_back = (shadow_back + DEPTH - 1) % DEPTH;
          shadow_ring[shadow_back] = val;
          shadow_held++;
        end
      end
      ACT_PUSH_FRONT: begin
        if (shadow_held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_ring[(shadow_back + shadow_held) % DEPTH] = val;
          shadow_held++;
        end
      end
      ACT_POP_BACK: begin
        if (shadow_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.word = shadow_ring[shadow_back];
          shadow_back = (shadow_back + 1) % DEPTH;
          shadow_held--;
        end
      end
      ACT_POP_FRONT: begin
        if (shadow_held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.word = shadow_ring[(shadow_back + shadow_held - 1) % DEPTH];
          shadow_held--;
        end
      end
      ACT_CLEAR: begin
        shadow_held = 0;
        shadow_back = 0;
      end
      ACT_COMPACT: begin
        // every third entry from the back end goes, the rest close up
        kept = 0;
        for (k = 0; k < shadow_held; k++) begin
          if ((k + 1) % DROP_EVERY != 0) begin
            shadow_ring[(shadow_back + kept) % DEPTH] =
              shadow_ring[(shadow_back + k) % DEPTH];
            kept++;
          end
        end
        shadow_held = kept;
      end
      default: ;
    endcase
    r.occ   = OCC_W'(shadow_held);
    r.empty = (shadow_held == 0);
    return r;
  endfunction

  // Idle length: mostly short, a few long, with runs of no idling at all
  function automatic int draw_gap(inout int quiet_left);
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 82) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [VALUE_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Action mix per phase; fill phases drive the store into full often
  function automatic logic [ACT_W-1:0] pick_action(mix_t mix);
    int               r;
    logic [ACT_W-1:0] a;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:
        a = (r < 50) ? ACT_PUSH_BACK : (r < 92) ? ACT_PUSH_FRONT :
            (r < 96) ? ACT_POP_BACK  : ACT_POP_FRONT;
      MIX_DRAIN:
        a = (r < 40) ? ACT_POP_BACK   : (r < 80) ? ACT_POP_FRONT :
            (r < 88) ? ACT_PUSH_BACK  : (r < 96) ? ACT_PUSH_FRONT :
            (r < 98) ? ACT_COMPACT    : ACT_CLEAR;
      MIX_ANY:
        a = (r < 20) ? ACT_PUSH_BACK : (r < 40) ? ACT_PUSH_FRONT :
            (r < 60) ? ACT_POP_BACK  : (r < 80) ? ACT_POP_FRONT :
            (r < 92) ? ACT_COMPACT   : ACT_CLEAR;
      default:
        a = (r < 30) ? ACT_PUSH_BACK : (r < 60) ? ACT_PUSH_FRONT :
            (r < 70) ? ACT_POP_BACK  : (r < 80) ? ACT_POP_FRONT : ACT_COMPACT;
    endcase
    if ($urandom_range(0, 99) == 0) a = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
    return a;
  endfunction

  task automatic add_item(logic [ACT_W-1:0] act, logic signed [VALUE_W-1:0] val);
    cmd_item_t item;
    item.action = act;
    item.value  = val;
    cmd_backlog.insert(cmd_backlog.size(), item);
  endtask

  task automatic log_mismatch(string msg);
    if (mismatches < PRINT_CAP) $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Driver: predicts on acceptance, then issues the next backlog item
  always @(posedge clk) begin : driver
    cmd_item_t item;
    if (rst) begin
      cmd_ch.valid  <= 1'b0;
      cmd_ch.action <= ACT_PUSH_BACK;
      cmd_ch.value  <= '0;
      idle_left     <= 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready)
        reply_fifo.insert(reply_fifo.size(),
                          apply_deque_action(cmd_ch.action, cmd_ch.value));
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (idle_left > 0) begin
          idle_left    <= idle_left - 1;
          cmd_ch.valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          item = cmd_backlog[0];
          cmd_backlog.delete(0);
          cmd_ch.valid  <= 1'b1;
          cmd_ch.action <= item.action;
          cmd_ch.value  <= item.value;
          idle_left     <= draw_gap(drv_quiet);
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each response item against the oldest prediction
  always @(posedge clk) begin : monitor
    reply_t want;
    int     stall;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (reply_fifo.size() == 0) begin
          log_mismatch("response item with no prediction waiting");
        end else begin
          want = reply_fifo[0];
          reply_fifo.delete(0);
          if (rsp_ch.popped_word !== want.word)
            log_mismatch($sformatf("popped_word got %0d expected %0d",
                                   rsp_ch.popped_word, want.word));
          if (rsp_ch.status !== want.status)
            log_mismatch($sformatf("status got %0d expected %0d",
                                   rsp_ch.status, want.status));
          if (rsp_ch.occupancy !== want.occ)
            log_mismatch($sformatf("occupancy got %0d expected %0d",
                                   rsp_ch.occupancy, want.occ));
          if (rsp_ch.is_empty !== want.empty)
            log_mismatch($sformatf("is_empty got %0b expected %0b",
                                   rsp_ch.is_empty, want.empty));
        end
      end
      // back-pressure: after each taken item, draw a random stall, often none
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left   <= stall_left - 1;
      end else if (rsp_ch.valid && rsp_ch.ready) begin
        stall = draw_gap(mon_quiet);
        rsp_ch.ready <= (stall == 0);
        stall_left   <= (stall > 0) ? stall - 1 : 0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int   issued;
    int   len;
    int   i;
    mix_t mix;

    // directed: empty-queue errors, extreme words, small compacts, spare codes
    add_item(ACT_POP_BACK,   32'h0000_0001);
    add_item(ACT_POP_FRONT,  32'h0000_0002);
    add_item(ACT_COMPACT,    '0);
    add_item(ACT_PUSH_BACK,  32'h7FFF_FFFF);
    add_item(ACT_PUSH_FRONT, 32'h8000_0000);
    add_item(ACT_COMPACT,    '0);
    add_item(ACT_POP_FRONT,  '0);
    add_item(ACT_POP_BACK,   '0);
    add_item(ACT_PUSH_BACK,  32'h0000_0000);
    add_item(ACT_PUSH_BACK,  32'hFFFF_FFFF);
    add_item(ACT_PUSH_FRONT, 32'h5555_5555);
    add_item(ACT_PUSH_FRONT, 32'hAAAA_AAAA);
    add_item(ACT_PUSH_BACK,  32'h0000_0001);
    add_item(ACT_COMPACT,    32'hFFFF_FFFF);
    add_item(ACT_POP_BACK,   '0);
    add_item(ACT_POP_FRONT,  '0);
    add_item(ACT_SPARE_6,    32'h1234_5678);
    add_item(ACT_SPARE_7,    32'hFFFF_FFFF);
    add_item(ACT_CLEAR,      '0);
    add_item(ACT_POP_FRONT,  '0);
    add_item(ACT_PUSH_FRONT, 32'h0000_3039);
    add_item(ACT_POP_BACK,   '0);

    // random phases of biased action mixes
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      mix = mix_t'($urandom_range(0, 3));
      len = $urandom_range(20, 90);
      for (i = 0; i < len; i++) add_item(pick_action(mix), random_word());
      issued += len;
    end

    while (rst) @(posedge clk);
    while (cmd_backlog.size() != 0 || cmd_ch.valid !== 1'b0) @(posedge clk);
    while (reply_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Reset held for the first cycles only
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

endmodule

// ===== double_ended_queue.f =====
src/deq_pkg.sv
src/deq_cmd_if.sv
src/deq_rsp_if.sv
src/deq_ram.sv
src/double_ended_queue.sv
sim/tb.sv
